FILE: sv/tdp_pkg.sv
package tdp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_DIVIDE,
    ST_EVAL,
    ST_FINISH
  } tdp_state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic next_divisor;
    logic set_verdict;
    logic verdict_value;
    logic load_out;
  } tdp_cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic n_lt4;
    logic n_even;
    logic div_last;
    logic quo_lt_d;
    logic rem_zero;
  } tdp_status_t;

endpackage

FILE: sv/trial_division_primality_test_unit.sv
// channel | valid        | stall        | payload
// input   | number_valid | number_stall | number [NUMBER_WIDTH-1:0]
// output  | result_valid | result_stall | is_prime
//
// Odd numbers run a restoring divider, one quotient bit per cycle, once for each
// odd trial divisor, up to about sqrt(number)/2 divisors; 0..3 and even numbers
// are decided without it. One item is in work at a time; the result register lets
// a new item enter while the previous result is still stalled, and a finished item
// waits until that result leaves.
// rst clears the controller and the result valid; datapath registers hold no reset.
module trial_division_primality_test_unit
  import tdp_pkg::*;
#(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    number_valid,
  output logic                    number_stall,
  input  logic [NUMBER_WIDTH-1:0] number,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic                    is_prime
);

  tdp_cmd_t    cmd;
  tdp_status_t status;

  tdp_controller u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .number_valid (number_valid),
    .number_stall (number_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  tdp_datapath #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_dp (
    .clk      (clk),
    .number   (number),
    .cmd      (cmd),
    .status   (status),
    .is_prime (is_prime)
  );

endmodule

FILE: sv/tdp_datapath.sv
module tdp_datapath
  import tdp_pkg::*;
#(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                    clk,
  input  logic [NUMBER_WIDTH-1:0] number,
  input  tdp_cmd_t                cmd,
  output tdp_status_t             status,
  output logic                    is_prime
);

  localparam int CW = $clog2(NUMBER_WIDTH);

  logic [NUMBER_WIDTH-1:0] held_number;
  logic [NUMBER_WIDTH-1:0] trial_divisor;
  logic [NUMBER_WIDTH-1:0] rem;
  logic [NUMBER_WIDTH-1:0] quo;
  logic [CW-1:0]           cnt;
  logic                    verdict;

  logic [NUMBER_WIDTH:0]   trial;
  logic [NUMBER_WIDTH:0]   diff;
  logic                    ge;
  logic [NUMBER_WIDTH-1:0] rem_next;
  logic [NUMBER_WIDTH-1:0] quo_next;

  always_comb begin
    trial    = {rem, quo[NUMBER_WIDTH-1]};
    diff     = trial - {1'b0, trial_divisor};
    ge       = ~diff[NUMBER_WIDTH];
    rem_next = ge ? diff[NUMBER_WIDTH-1:0] : trial[NUMBER_WIDTH-1:0];
    quo_next = {quo[NUMBER_WIDTH-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held_number   <= number;
      trial_divisor <= NUMBER_WIDTH'(3);
    end
    if (cmd.next_divisor) begin
      trial_divisor <= trial_divisor + NUMBER_WIDTH'(2);
    end
    if (cmd.div_start) begin
      rem <= '0;
      quo <= held_number;
      cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_next;
      quo <= quo_next;
      cnt <= cnt + CW'(1);
    end
    if (cmd.set_verdict) begin
      verdict <= cmd.verdict_value;
    end
    if (cmd.load_out) begin
      is_prime <= verdict;
    end
  end

  always_comb begin
    status.n_lt2    = held_number < NUMBER_WIDTH'(2);
    status.n_lt4    = held_number < NUMBER_WIDTH'(4);
    status.n_even   = ~held_number[0];
    status.div_last = cnt == CW'(NUMBER_WIDTH - 1);
    status.quo_lt_d = quo < trial_divisor;
    status.rem_zero = rem == '0;
  end

endmodule

FILE: sv/tdp_controller.sv
module tdp_controller
  import tdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        number_valid,
  output logic        number_stall,
  output logic        result_valid,
  input  logic        result_stall,
  input  tdp_status_t status,
  output tdp_cmd_t    cmd
);

  tdp_state_t state;
  tdp_state_t state_next;
  logic       out_free;

  assign out_free = ~result_valid | ~result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (~result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (number_valid) state_next = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        if (status.n_lt2 || status.n_lt4 || status.n_even) state_next = ST_FINISH;
        else state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status.div_last) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (status.quo_lt_d || status.rem_zero) state_next = ST_FINISH;
        else state_next = ST_DIVIDE;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    number_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        number_stall = 1'b0;
        cmd.load     = number_valid;
      end
      ST_CLASSIFY: begin
        if (status.n_lt2) begin
          cmd.set_verdict   = 1'b1;
          cmd.verdict_value = 1'b0;
        end else if (status.n_lt4) begin
          cmd.set_verdict   = 1'b1;
          cmd.verdict_value = 1'b1;
        end else if (status.n_even) begin
          cmd.set_verdict   = 1'b1;
          cmd.verdict_value = 1'b0;
        end else begin
          cmd.div_start = 1'b1;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      ST_EVAL: begin
        if (status.quo_lt_d) begin
          cmd.set_verdict   = 1'b1;
          cmd.verdict_value = 1'b1;
        end else if (status.rem_zero) begin
          cmd.set_verdict   = 1'b1;
          cmd.verdict_value = 1'b0;
        end else begin
          cmd.next_divisor = 1'b1;
          cmd.div_start    = 1'b1;
        end
      end
      ST_FINISH: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: sv/tdp_checker.sv
module tdp_checker #(
  parameter int NUMBER_WIDTH = 32
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    number_valid,
  input logic                    number_stall,
  input logic [NUMBER_WIDTH-1:0] number,
  input logic                    result_valid,
  input logic                    result_stall,
  input logic                    is_prime
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(is_prime))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    number_valid && number_stall |=> number_valid && $stable(number))
    else $error("stalled input item changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    number_valid && !number_stall |=> number_stall)
    else $error("item accepted while busy");

  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !number_stall)
    else $error("result raised while not idle");

  a_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !result_valid && !number_stall)
    else $error("not idle after reset");

endmodule

bind trial_division_primality_test_unit tdp_checker #(
  .NUMBER_WIDTH (NUMBER_WIDTH)
) u_tdp_checker (
  .clk          (clk),
  .rst          (rst),
  .number_valid (number_valid),
  .number_stall (number_stall),
  .number       (number),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .is_prime     (is_prime)
);
